FILE: hw/rtl/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Clocked assertion helpers shared by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Checked on every edge while out of reset.
`define PLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Operation, status and cell command types shared by the list engine modules.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_READ      = 3'd2,
        FN_WRITE     = 3'd3,
        FN_REMOVE    = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_SET,
        CELL_REMOVE,
        CELL_READ
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

FILE: hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry; shifts from either neighbor, loads or is read.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [IW-1:0]     i_target,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_read
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              hit;

    assign hit = (i_target == MY_IDX);

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op) inside
            CELL_PUSH_FRONT: n_data = i_left;
            CELL_SET:        n_data = hit ? i_cmd.value : r_data;
            // cells at or beyond the removed slot pull from the right
            CELL_REMOVE:     n_data = (i_target <= MY_IDX) ? i_right : r_data;
            CELL_HOLD,
            CELL_READ:       n_data = r_data;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_read = (i_cmd.op == CELL_READ && hit) ? r_data : '0;

endmodule

FILE: hw/rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list engine control
// Decodes one transaction into a cell command, status and next count.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
#(
    parameter  int CAPACITY = 64,
    localparam int IW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int PW       = (CW > POS_W) ? CW : POS_W
) (
    input  logic [FUNC_W-1:0] i_func,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_value,
    input  logic [CW-1:0]     i_count,
    output t_cell_cmd         o_cmd,
    output logic [IW-1:0]     o_target,
    output t_status           o_status,
    output logic [CW-1:0]     o_next_count
);

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] pos_m1;
    logic          pos_ok;
    logic          full;

    assign pos_ext = PW'(i_position);
    assign cnt_ext = PW'(i_count);
    assign pos_m1  = pos_ext - PW'(1);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign full    = (i_count == CW'(CAPACITY));

    always_comb begin
        o_cmd.op     = CELL_HOLD;
        o_cmd.value  = i_value;
        o_target     = pos_m1[IW-1:0];
        o_status     = ST_OK;
        o_next_count = i_count;
        unique case (i_func)
            FN_INS_FRONT: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.op     = CELL_PUSH_FRONT;
                    o_next_count = i_count + CW'(1);
                end
            end
            FN_INS_BACK: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.op     = CELL_SET;
                    o_target     = i_count[IW-1:0];
                    o_next_count = i_count + CW'(1);
                end
            end
            FN_READ: begin
                if (pos_ok) o_cmd.op = CELL_READ;
                else        o_status = ST_BADPOS;
            end
            FN_WRITE: begin
                if (pos_ok) o_cmd.op = CELL_SET;
                else        o_status = ST_BADPOS;
            end
            FN_REMOVE: begin
                if (pos_ok) begin
                    o_cmd.op     = CELL_REMOVE;
                    o_next_count = i_count - CW'(1);
                end else begin
                    o_status = ST_BADPOS;
                end
            end
            default: o_status = ST_BADPOS;
        endcase
    end

endmodule

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// One transaction per clock: busy is never raised, and each accepted
// transaction returns its result with o_done in the next cycle. The
// rate is set by the cell row, where every cell loads, shifts toward either
// neighbor or is read in the same edge; a read gathers the addressed cell
// through an OR across the row. Results cannot be held off and must be taken
// in the o_done cycle. Cell contents come out of reset undefined; only
// entries 1 to count are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_done,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_read_data,
    output logic [CNT_W-1:0]         o_entry_count
);

`include "positional_list_engine_macros.svh"

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > CNT_W) ? CW : CNT_W;

    logic              accept;
    t_cell_cmd         cmd;
    logic [IW-1:0]     target;
    t_status           status;
    logic [CW-1:0]     n_count;
    logic [DATA_W-1:0] cell_q  [CAPACITY];
    logic [DATA_W-1:0] cell_rd [CAPACITY];
    logic [DATA_W-1:0] rd_or;
    logic [PW-1:0]     cnt_wide;

    logic [CW-1:0]     r_count;
    logic              r_done;
    t_status           r_status;
    logic [DATA_W-1:0] r_read_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_func       (i_func),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_count      (r_count),
        .o_cmd        (cmd),
        .o_target     (target),
        .o_status     (status),
        .o_next_count (n_count)
    );

    t_cell_cmd cell_cmd;

    always_comb begin
        cell_cmd = cmd;
        if (!accept) cell_cmd.op = CELL_HOLD;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;

        if (g == 0) begin : g_head
            assign left = cmd.value;
        end else begin : g_mid
            assign left = cell_q[g-1];
        end

        // tail cell has nothing behind it; it reloads its own value on removal
        if (g == CAPACITY - 1) begin : g_tail
            assign right = cell_q[g];
        end else begin : g_body
            assign right = cell_q[g+1];
        end

        ple_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_cmd    (cell_cmd),
            .i_target (target),
            .i_left   (left),
            .i_right  (right),
            .o_data   (cell_q[g]),
            .o_read   (cell_rd[g])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= accept;
            if (accept) r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_read_data <= rd_or;
        end
    end

    assign cnt_wide      = PW'(r_count);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_entry_count = cnt_wide[CNT_W-1:0];

    `PLE_ASSERT(a_done_follows_accept, accept |=> o_done, "result missing after transaction")
    `PLE_ASSERT(a_no_spurious_done, !accept |=> !o_done, "result without transaction")
    `PLE_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "count above capacity")
    `PLE_ASSERT(a_full_means_full, (o_done && o_status == ST_FULL) |-> (r_count == CW'(CAPACITY)), "full status with room left")
    `PLE_ASSERT(a_rd_zero_on_error, (o_done && o_status != ST_OK) |-> (o_read_data == '0), "read data on failed transaction")
    `PLE_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_done, "result right after reset")

endmodule

FILE: dv/positional_list_engine_tb.sv
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list commands through the start/busy handshake and checks every
// o_done result against a shadow copy of the list, kept as a row of cells
// with the head in cell 0. Directed corner commands come first, then random
// fill and drain sweeps across three sender idle profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int CAP            = 64;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int PHASE_ITEMS    = 640;
    localparam int STALL_LIMIT    = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 10;
    localparam logic [FUNC_W-1:0] FUNC_CODE_MAX = '1;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]         entry_count;
    } t_reply;

    // Shadow of the list plus the queue of replies it predicts.
    class list_shadow;
        logic [DATA_W-1:0] cells [CAP];
        int unsigned       count;
        t_reply            replies [$];
        int unsigned       failures;
        int unsigned       checked;
        int unsigned       full_rejects;
        int unsigned       pos_rejects;
        int unsigned       reads_ok;
        int unsigned       peak;

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function void note_command(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] val);
            t_reply r;
            bit     pos_ok;
            r.status    = ST_OK;
            r.read_data = '0;
            pos_ok = (pos >= 1) && (pos <= count);
            case (func) inside
                FN_INS_FRONT, FN_INS_BACK: begin
                    if (count >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        if (func == FN_INS_FRONT) begin
                            for (int i = count; i > 0; i--)
                                cells[i] = cells[i-1];
                            cells[0] = val;
                        end else begin
                            cells[count] = val;
                        end
                        count++;
                    end
                end
                FN_READ: begin
                    if (pos_ok) r.read_data = cells[pos-1];
                    else r.status = ST_BADPOS;
                end
                FN_WRITE: begin
                    if (pos_ok) cells[pos-1] = val;
                    else r.status = ST_BADPOS;
                end
                FN_REMOVE: begin
                    if (pos_ok) begin
                        for (int i = pos - 1; i + 1 < count; i++)
                            cells[i] = cells[i+1];
                        count--;
                    end else begin
                        r.status = ST_BADPOS;
                    end
                end
                default: r.status = ST_BADPOS;
            endcase
            if (r.status == ST_FULL) full_rejects++;
            if (r.status == ST_BADPOS) pos_rejects++;
            if (func == FN_READ && r.status == ST_OK) reads_ok++;
            if (count > peak) peak = count;
            r.entry_count = CNT_W'(count);
            replies.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] rd,
                                   logic [CNT_W-1:0] cnt);
            t_reply e;
            if (replies.size() == 0) begin
                flag($sformatf("result with nothing pending: status=%0d data=%0d count=%0d",
                               status, rd, cnt));
                return;
            end
            e = replies.pop_front();
            checked++;
            if (status !== e.status)
                flag($sformatf("status exp=%0d got=%0d", e.status, status));
            if (rd !== e.read_data)
                flag($sformatf("read_data exp=%0d got=%0d", e.read_data, rd));
            if (cnt !== e.entry_count)
                flag($sformatf("entry_count exp=%0d got=%0d", e.entry_count, cnt));
        endfunction

        function int unsigned pending();
            return replies.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [FUNC_W-1:0]        i_func;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_done;
    logic [STAT_W-1:0]        o_status;
    logic signed [DATA_W-1:0] o_read_data;
    logic [CNT_W-1:0]         o_entry_count;

    list_shadow  shadow;
    int unsigned stall_cycles;
    int unsigned commands_sent;
    bit          filling;

    positional_list_engine #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_entry_count (o_entry_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Accepted command first, so even a same-cycle reply finds its entry.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                shadow.note_command(i_func, i_position, i_value);
            if (o_done)
                shadow.check_result(o_status, o_read_data, o_entry_count);
            if ((start && !busy) || o_done) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                    $display("positional_list_engine verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_command(input logic [FUNC_W-1:0] func, input int unsigned pos,
                                input logic [DATA_W-1:0] val);
        start      <= 1'b1;
        i_func     <= func;
        i_position <= POS_W'(pos);
        i_value    <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        commands_sent++;
    endtask

    // Geometric idle runs: on average pct of the cycles carry no command.
    task automatic hold_off(input int unsigned pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
    endtask

    task automatic pick_position(input bit want_valid, output int unsigned pos);
        int unsigned cnt;
        cnt = shadow.count;
        if (want_valid && cnt > 0)
            pos = $urandom_range(cnt, 1);
        else if (cnt < CAP && $urandom_range(1))
            pos = $urandom_range(CAP, cnt + 1);
        else
            pos = 0;
    endtask

    // Fill sweeps lean on inserts until the list is full, drain sweeps on
    // removes until it is empty; a few malformed commands ride along.
    task automatic pick_command(output logic [FUNC_W-1:0] func, output int unsigned pos,
                                output logic [DATA_W-1:0] val);
        int unsigned roll;
        roll = $urandom_range(99);
        val  = $urandom;
        if (filling && shadow.count >= CAP && $urandom_range(3) == 0) filling = 1'b0;
        if (!filling && shadow.count == 0 && $urandom_range(1) == 0) filling = 1'b1;
        if (roll < 2)
            func = FUNC_W'($urandom_range(FUNC_CODE_MAX, FN_REMOVE + 1));
        else if (roll < (filling ? 62 : 12))
            func = $urandom_range(1) ? FN_INS_FRONT : FN_INS_BACK;
        else if (roll < (filling ? 76 : 26))
            func = FN_READ;
        else if (roll < (filling ? 88 : 38))
            func = FN_WRITE;
        else
            func = FN_REMOVE;
        pick_position($urandom_range(9) != 0, pos);
    endtask

    task automatic random_phase(input int unsigned items, input int unsigned idle_pct);
        logic [FUNC_W-1:0] func;
        int unsigned       pos;
        logic [DATA_W-1:0] val;
        repeat (items) begin
            hold_off(idle_pct);
            pick_command(func, pos, val);
            send_command(func, pos, val);
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_func        = FN_READ;
        i_position    = '0;
        i_value       = '0;
        stall_cycles  = 0;
        commands_sent = 0;
        filling       = 1'b1;
        shadow        = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every positional command is rejected
        send_command(FN_READ, 1, 32'h0);
        send_command(FN_REMOVE, 0, 32'h0);
        send_command(FN_WRITE, 1, 32'h1234_5678);
        send_command(FN_REMOVE, 1, 32'h0);
        send_command(FN_INS_BACK, 0, 32'h7FFF_FFFF);
        send_command(FN_INS_FRONT, 0, 32'h8000_0000);
        send_command(FN_INS_BACK, CAP, 32'h0);
        send_command(FN_INS_FRONT, 1, 32'hFFFF_FFFF);
        send_command(FN_READ, 0, 32'h0);
        for (int p = 1; p <= 4; p++) send_command(FN_READ, p, 32'h0);
        send_command(FN_READ, 5, 32'h0);
        send_command(FN_WRITE, 4, 32'hAAAA_5555);
        send_command(FN_WRITE, CAP, 32'h5555_AAAA);
        send_command(FN_READ, CAP, 32'h0);
        send_command(FN_REMOVE, 2, 32'h0);
        send_command(FN_REMOVE, 1, 32'h0);
        send_command(FN_READ, 2, 32'h0);
        send_command(FN_REMOVE, 2, 32'h0);
        for (int f = FN_REMOVE + 1; f <= FUNC_CODE_MAX; f++)
            send_command(FUNC_W'(f), 1, 32'hFFFF_FFFF);
        send_command(FN_READ, 1, 32'h0);
        wait_replies();

        random_phase(PHASE_ITEMS, 31);
        wait_replies();
        random_phase(PHASE_ITEMS, 72);
        wait_replies();
        random_phase(PHASE_ITEMS, 0);
        wait_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.pending() != 0)
            shadow.flag($sformatf("%0d results never arrived", shadow.pending()));
        $display("Ran %0d commands, %0d results checked, list peaked at %0d entries",
                 commands_sent, shadow.checked, shadow.peak);
        $display("Rejects seen: %0d full-list inserts, %0d bad positions; %0d good reads",
                 shadow.full_rejects, shadow.pos_rejects, shadow.reads_ok);
        if (shadow.failures == 0) begin
            $display("positional_list_engine verification clean");
        end else begin
            $display("%0d mismatches", shadow.failures);
            $display("positional_list_engine verification failed");
        end
        $finish;
    end

endmodule
